// ===== rtl/tti_pkg.sv =====
// Package for the tracking table interpolator.
// Holds the state encoding, operation and register codes and fixed field widths.
// No dependencies.
package tti_pkg;

    localparam int OP_W     = 2;
    localparam int IDX_W    = 8;
    localparam int VALUE_W  = 32;
    localparam int RESULT_W = 40;
    localparam int STEP_W   = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [OP_W-1:0] OP_WRITE   = 2'd0;
    localparam logic [OP_W-1:0] OP_FORWARD = 2'd1;
    localparam logic [OP_W-1:0] OP_REVERSE = 2'd2;
    localparam logic [OP_W-1:0] OP_UNUSED  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_TREND_UP   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_VALUE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_INDEX = 2'd3;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_F_RD,
        ST_F_CMP,
        ST_F_RD2,
        ST_F_CMP2,
        ST_F_NUM,
        ST_F_MULN,
        ST_F_DLD,
        ST_F_DIVF,
        ST_F_END,
        ST_F_MULP,
        ST_R_DIVD,
        ST_R_CHK,
        ST_R_RD,
        ST_R_LO,
        ST_R_RD2,
        ST_R_HI,
        ST_R_MUL,
        ST_R_DLD,
        ST_R_DIVF,
        ST_OUT
    } t_state;

endpackage

// ===== rtl/tti_in_if.sv =====
// Input channel of the tracking table interpolator: valid/ready plus item fields.
// Depends on tti_pkg.
interface tti_in_if import tti_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [OP_W-1:0]            operation;
    logic [IDX_W-1:0]           entry_index;
    logic signed [VALUE_W-1:0]  value;

    modport source (output valid, operation, entry_index, value, input ready);
    modport sink   (input valid, operation, entry_index, value, output ready);
endinterface

// ===== rtl/tti_out_if.sv =====
// Output channel of the tracking table interpolator: valid/ready plus result fields.
// Depends on tti_pkg.
interface tti_out_if import tti_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [RESULT_W-1:0] result_q8;
    logic                       out_of_range;

    modport source (output valid, result_q8, out_of_range, input ready);
    modport sink   (input valid, result_q8, out_of_range, output ready);
endinterface

// ===== rtl/tracking_table_interpolator.sv =====
// Tracking table interpolator top level: table RAM, bracket search, serial
// multiplier and serial divider. Depends on tti_pkg, tti_in_if, tti_out_if, tti_ram.
//
//   channel  | dir | handshake          | payload
//   i_in     | in  | valid/ready        | operation, entry_index, value
//   o_out    | out | valid/ready        | result_q8, out_of_range
//   cfg      | in  | i_cfg_we           | i_cfg_idx, i_cfg_data
//
// Write and unused items are finished in the idle state that takes them. A forward
// lookup reads and compares one table entry per probe of the bracket walk, then
// makes a pass of the bit-serial multiplier; when a fraction is needed, another
// multiplier pass and a divider pass are added. A reverse lookup takes one divider
// pass; between entries it adds a multiplier pass and a second divider pass.
// Synchronous active-low reset; the table RAM is not cleared. A new item is
// taken while a finished result still waits in the output register; a lookup
// holds in its last state until that register is free.
module tracking_table_interpolator import tti_pkg::*; #(
    parameter int TABLE_DEPTH   = 256,
    parameter int ENTRY_WIDTH   = 32,
    parameter int FRACTION_BITS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    tti_in_if.sink                i_in,
    tti_out_if.source             o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int NW = 48 + FRACTION_BITS;
    localparam int CW = $clog2(NW);

    t_state r_state, n_state;

    logic                       r_trend_up, n_trend_up;
    logic [STEP_W-1:0]          r_step_size, n_step_size;
    logic signed [15:0]         r_base_value, n_base_value;
    logic [7:0]                 r_last_index, n_last_index;

    logic [7:0]                 r_spos, n_spos;
    logic [7:0]                 r_p, n_p;
    logic                       r_fwd, n_fwd;
    logic                       r_dir, n_dir;
    logic                       r_frac, n_frac;
    logic                       r_oor, n_oor;
    logic                       r_neg, n_neg;
    logic signed [32:0]         r_v, n_v;
    logic signed [32:0]         r_t, n_t;
    logic signed [32:0]         r_lo, n_lo;
    logic signed [32:0]         r_hi, n_hi;
    logic [STEP_W-1:0]          r_j, n_j;
    logic [31:0]                r_mc, n_mc;
    logic [47:0]                r_mp, n_mp;
    logic [NW-1:0]              r_dq, n_dq;
    logic [31:0]                r_rem, n_rem;
    logic [31:0]                r_dvs, n_dvs;
    logic [CW-1:0]              r_cnt, n_cnt;
    logic                       r_ovalid, n_ovalid;
    logic [RESULT_W-1:0]        r_res, n_res;
    logic                       r_ooor, n_ooor;

    logic                       ram_we;
    logic [ENTRY_WIDTH-1:0]     ram_rdata;
    logic signed [32:0]         ent;
    logic [7:0]                 top;
    logic [STEP_W-1:0]          step;
    logic                       gu, gd, out_free, accept;
    logic [32:0]                mul_sum, div_sh, div_sub;
    logic                       div_ge, q_hi, i_gt, i_eq;
    logic signed [32:0]         dval, num, den, diff;
    logic [RESULT_W-1:0]        bt, fpart, lo_sh, res_fwd, res_rev;

    tti_ram #(.WIDTH(ENTRY_WIDTH), .DEPTH(TABLE_DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (AW'(i_in.entry_index)),
        .i_wdata (i_in.value[ENTRY_WIDTH-1:0]),
        .i_raddr (AW'(r_p)),
        .o_rdata (ram_rdata)
    );

    assign ent    = 33'($signed(ram_rdata));
    assign top    = (32'(r_last_index) > TABLE_DEPTH - 1) ? 8'(TABLE_DEPTH - 1) : r_last_index;
    assign step   = (r_step_size == '0) ? STEP_W'(1) : r_step_size;
    assign accept = i_in.valid && (r_state == ST_IDLE);
    assign ram_we = accept && (i_in.operation == OP_WRITE)
                    && (32'(i_in.entry_index) < TABLE_DEPTH);
    assign out_free = !r_ovalid || o_out.ready;

    assign gu = r_trend_up ? (r_v > ent) : (r_v < ent);
    assign gd = r_trend_up ? (r_v < ent) : (r_v > ent);

    assign mul_sum = {1'b0, r_mp[47:16]} + (r_mp[0] ? {1'b0, r_mc} : 33'd0);
    assign div_sh  = {r_rem, r_dq[NW-1]};
    assign div_sub = div_sh - {1'b0, r_dvs};
    assign div_ge  = (div_sh >= {1'b0, r_dvs});

    assign q_hi = |r_dq[NW-1:8];
    assign i_gt = q_hi || (r_dq[7:0] > top);
    assign i_eq = !q_hi && (r_dq[7:0] == top);

    assign dval = 33'(signed'(i_in.value)) - 33'(r_base_value);
    assign num  = r_trend_up ? (r_v - r_lo) : (r_lo - r_v);
    assign den  = r_trend_up ? (r_hi - r_lo) : (r_lo - r_hi);
    assign diff = ent - r_lo;

    assign fpart   = r_frac ? r_dq[RESULT_W-1:0] : '0;
    assign bt      = RESULT_W'(r_mp) + RESULT_W'(r_base_value);
    assign res_fwd = (bt << FRACTION_BITS) + fpart;
    assign lo_sh   = RESULT_W'(r_lo) << FRACTION_BITS;
    assign res_rev = r_neg ? (lo_sh - fpart) : (lo_sh + fpart);

    always_comb begin
        n_state = r_state;
        n_trend_up = r_trend_up;
        n_step_size = r_step_size;
        n_base_value = r_base_value;
        n_last_index = r_last_index;
        n_spos = r_spos;
        n_p = r_p;
        n_fwd = r_fwd;
        n_dir = r_dir;
        n_frac = r_frac;
        n_oor = r_oor;
        n_neg = r_neg;
        n_v = r_v;
        n_t = r_t;
        n_lo = r_lo;
        n_hi = r_hi;
        n_j = r_j;
        n_mc = r_mc;
        n_mp = r_mp;
        n_dq = r_dq;
        n_rem = r_rem;
        n_dvs = r_dvs;
        n_cnt = r_cnt;
        n_ovalid = r_ovalid;
        n_res = r_res;
        n_ooor = r_ooor;

        if (r_ovalid && o_out.ready) begin
            n_ovalid = 1'b0;
        end

        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TREND_UP:   n_trend_up = i_cfg_data[0];
                CFG_STEP_SIZE:  n_step_size = i_cfg_data;
                CFG_BASE_VALUE: n_base_value = signed'(i_cfg_data);
                CFG_LAST_INDEX: n_last_index = i_cfg_data[7:0];
                default: ;
            endcase
        end

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_v = 33'(signed'(i_in.value));
                    n_frac = 1'b0;
                    n_oor = 1'b0;
                    n_neg = 1'b0;
                    case (i_in.operation)
                        OP_FORWARD: begin
                            n_fwd = 1'b1;
                            n_p = (r_spos > top) ? top : r_spos;
                            n_state = ST_F_RD;
                        end
                        OP_REVERSE: begin
                            n_fwd = 1'b0;
                            if (dval < 0) begin
                                n_oor = 1'b1;
                                n_p = '0;
                                n_state = ST_R_RD;
                            end else begin
                                n_dq = NW'(dval[31:0]);
                                n_rem = '0;
                                n_dvs = 32'(step);
                                n_cnt = CW'(NW - 1);
                                n_state = ST_R_DIVD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_F_RD: n_state = ST_F_CMP;
            ST_F_CMP: begin
                n_t = ent;
                if (gu) begin
                    if (r_p >= top) begin
                        n_oor = 1'b1;
                        n_state = ST_F_END;
                    end else begin
                        n_p = r_p + 8'd1;
                        n_dir = 1'b1;
                        n_state = ST_F_RD2;
                    end
                end else if (gd) begin
                    if (r_p == '0) begin
                        n_oor = 1'b1;
                        n_state = ST_F_END;
                    end else begin
                        n_p = r_p - 8'd1;
                        n_dir = 1'b0;
                        n_state = ST_F_RD2;
                    end
                end else begin
                    n_state = ST_F_END;
                end
            end
            ST_F_RD2: n_state = ST_F_CMP2;
            ST_F_CMP2: begin
                n_state = ST_F_RD;
                if (r_dir) begin
                    if (gd) begin
                        n_p = r_p - 8'd1;
                        n_lo = r_t;
                        n_hi = ent;
                        n_frac = 1'b1;
                        n_state = ST_F_NUM;
                    end
                end else if (gu) begin
                    n_lo = ent;
                    n_hi = r_t;
                    n_frac = 1'b1;
                    n_state = ST_F_NUM;
                end
            end
            ST_F_NUM: begin
                n_mc = num[31:0];
                n_dvs = den[31:0];
                n_mp = {32'd0, step};
                n_cnt = CW'(15);
                n_state = ST_F_MULN;
            end
            ST_F_MULN: begin
                n_mp = {mul_sum, r_mp[15:1]};
                n_cnt = r_cnt - CW'(1);
                if (r_cnt == '0) begin
                    n_state = ST_F_DLD;
                end
            end
            ST_F_DLD: begin
                n_dq = NW'(r_mp) << FRACTION_BITS;
                n_rem = '0;
                n_cnt = CW'(NW - 1);
                n_state = ST_F_DIVF;
            end
            ST_F_DIVF: begin
                n_dq = {r_dq[NW-2:0], div_ge};
                n_rem = div_ge ? div_sub[31:0] : div_sh[31:0];
                n_cnt = r_cnt - CW'(1);
                if (r_cnt == '0) begin
                    n_state = ST_F_END;
                end
            end
            ST_F_END: begin
                n_spos = r_p;
                n_mc = 32'(r_p);
                n_mp = {32'd0, step};
                n_cnt = CW'(15);
                n_state = ST_F_MULP;
            end
            ST_F_MULP: begin
                n_mp = {mul_sum, r_mp[15:1]};
                n_cnt = r_cnt - CW'(1);
                if (r_cnt == '0) begin
                    n_state = ST_OUT;
                end
            end
            ST_R_DIVD: begin
                n_dq = {r_dq[NW-2:0], div_ge};
                n_rem = div_ge ? div_sub[31:0] : div_sh[31:0];
                n_cnt = r_cnt - CW'(1);
                if (r_cnt == '0) begin
                    n_state = ST_R_CHK;
                end
            end
            ST_R_CHK: begin
                n_j = r_rem[STEP_W-1:0];
                if (i_gt || (i_eq && r_rem != '0)) begin
                    n_oor = 1'b1;
                    n_p = top;
                end else begin
                    n_p = r_dq[7:0];
                end
                n_state = ST_R_RD;
            end
            ST_R_RD: n_state = ST_R_LO;
            ST_R_LO: begin
                n_lo = ent;
                if (r_oor || r_j == '0) begin
                    n_state = ST_OUT;
                end else begin
                    n_p = r_p + 8'd1;
                    n_state = ST_R_RD2;
                end
            end
            ST_R_RD2: n_state = ST_R_HI;
            ST_R_HI: begin
                n_neg = diff < 0;
                n_mc = (diff < 0) ? 32'(-diff) : diff[31:0];
                n_mp = {32'd0, r_j};
                n_cnt = CW'(15);
                n_state = ST_R_MUL;
            end
            ST_R_MUL: begin
                n_mp = {mul_sum, r_mp[15:1]};
                n_cnt = r_cnt - CW'(1);
                if (r_cnt == '0) begin
                    n_state = ST_R_DLD;
                end
            end
            ST_R_DLD: begin
                n_dq = NW'(r_mp) << FRACTION_BITS;
                n_rem = '0;
                n_dvs = 32'(step);
                n_cnt = CW'(NW - 1);
                n_state = ST_R_DIVF;
            end
            ST_R_DIVF: begin
                n_dq = {r_dq[NW-2:0], div_ge};
                n_rem = div_ge ? div_sub[31:0] : div_sh[31:0];
                n_cnt = r_cnt - CW'(1);
                if (r_cnt == '0) begin
                    n_frac = 1'b1;
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    n_res = r_fwd ? res_fwd : res_rev;
                    n_ooor = r_oor;
                    n_ovalid = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_trend_up <= 1'b1;
            r_step_size <= STEP_W'(1);
            r_base_value <= '0;
            r_last_index <= 8'd255;
            r_spos <= '0;
            r_ovalid <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_state <= n_state;
            r_trend_up <= n_trend_up;
            r_step_size <= n_step_size;
            r_base_value <= n_base_value;
            r_last_index <= n_last_index;
            r_spos <= n_spos;
            r_ovalid <= n_ovalid;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p <= n_p;
        r_fwd <= n_fwd;
        r_dir <= n_dir;
        r_frac <= n_frac;
        r_oor <= n_oor;
        r_neg <= n_neg;
        r_v <= n_v;
        r_t <= n_t;
        r_lo <= n_lo;
        r_hi <= n_hi;
        r_j <= n_j;
        r_mc <= n_mc;
        r_mp <= n_mp;
        r_dq <= n_dq;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
        r_res <= n_res;
        r_ooor <= n_ooor;
    end

    assign i_in.ready         = (r_state == ST_IDLE);
    assign o_out.valid        = r_ovalid;
    assign o_out.result_q8    = r_res;
    assign o_out.out_of_range = r_ooor;

    a_probe_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_F_RD || r_state == ST_R_RD2) |-> r_p <= top)
        else $error("table probe beyond last index");
    a_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> r_state == ST_IDLE)
        else $error("table write outside idle");
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_F_DIVF || r_state == ST_R_DIVF || r_state == ST_R_DIVD) |-> r_dvs != '0)
        else $error("divide by zero");
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT && out_free) |=> (r_ovalid && r_state == ST_IDLE))
        else $error("result not loaded");
endmodule

// ===== rtl/tti_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module tti_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== dv/tti_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the tracking table interpolator: watches both channels and the
// register port, predicts each lookup result and compares it field by field.
// Depends on tti_pkg, tti_in_if, tti_out_if.
module tti_checker import tti_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    tti_in_if                     in_ch,
    tti_out_if                    out_ch,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending
);

    localparam int FRACTION_BITS_TB = 8;

    typedef longint unsigned t_u64;

    typedef struct packed {
        logic [RESULT_W-1:0] result_q8;
        logic                out_of_range;
    } t_lookup;

    t_lookup                   lookup_q[$];
    logic signed [VALUE_W-1:0] entries[256];
    logic [7:0]                track_pos;
    bit                        rising;
    logic [15:0]               step_reg;
    logic signed [15:0]        base_reg;
    logic [7:0]                last_reg;
    int                        fails = 0;

    assign o_fail_count = fails;

    function automatic longint entry(int i);
        return longint'(entries[i & 255]);
    endfunction

    function automatic t_lookup forward_result(longint v);
        int      top, p;
        longint  stp, t, lo, hi, num, den;
        bit      frac, oor, up;
        t_u64    r;
        t_lookup res;
        top  = last_reg;
        stp  = (step_reg == 0) ? 1 : step_reg;
        p    = (track_pos > top) ? top : track_pos;
        up   = rising;
        frac = 0;
        oor  = 0;
        for (int n = 0; n <= 256; n++) begin
            t = entry(p);
            if (up ? (v > t) : (v < t)) begin
                if (p >= top) begin
                    oor = 1;
                    break;
                end
                p++;
                t = entry(p);
                if (up ? (v < t) : (v > t)) begin
                    p--;
                    frac = 1;
                    break;
                end
            end else if (up ? (v < t) : (v > t)) begin
                if (p == 0) begin
                    oor = 1;
                    break;
                end
                p--;
                t = entry(p);
                if (up ? (v > t) : (v < t)) begin
                    frac = 1;
                    break;
                end
            end else begin
                break;
            end
        end
        track_pos = p[7:0];
        r = t_u64'(longint'(p) * stp + longint'(base_reg)) << FRACTION_BITS_TB;
        if (frac) begin
            lo  = entry(p);
            hi  = entry(p + 1);
            num = up ? v - lo : lo - v;
            den = up ? hi - lo : lo - hi;
            if (den > 0 && num >= 0)
                r += ((t_u64'(num) * t_u64'(stp)) << FRACTION_BITS_TB) / t_u64'(den);
        end
        res.result_q8    = r[RESULT_W-1:0];
        res.out_of_range = oor;
        return res;
    endfunction

    function automatic t_lookup reverse_result(longint v);
        int      top;
        longint  stp, d, diff;
        t_u64    i, j, r, mag, q, f;
        t_lookup res;
        top = last_reg;
        stp = (step_reg == 0) ? 1 : step_reg;
        d   = v - longint'(base_reg);
        res.out_of_range = 0;
        if (d < 0) begin
            res.out_of_range = 1;
            r = t_u64'(entry(0)) << FRACTION_BITS_TB;
        end else begin
            i = t_u64'(d) / t_u64'(stp);
            j = t_u64'(d) % t_u64'(stp);
            if (i > top || (i == top && j != 0)) begin
                res.out_of_range = 1;
                r = t_u64'(entry(top)) << FRACTION_BITS_TB;
            end else begin
                r = t_u64'(entry(int'(i))) << FRACTION_BITS_TB;
                if (j != 0) begin
                    diff = entry(int'(i) + 1) - entry(int'(i));
                    mag  = (diff < 0) ? t_u64'(-diff) : t_u64'(diff);
                    q    = mag * j;
                    f    = ((q / t_u64'(stp)) << FRACTION_BITS_TB)
                         + (((q % t_u64'(stp)) << FRACTION_BITS_TB) / t_u64'(stp));
                    r    = (diff < 0) ? r - f : r + f;
                end
            end
        end
        res.result_q8 = r[RESULT_W-1:0];
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_lookup want;
        if (!i_rst_n) begin
            lookup_q.delete();
            track_pos = '0;
            rising    = 1;
            step_reg  = 16'd1;
            base_reg  = '0;
            last_reg  = 8'd255;
        end else begin
            // result beat belongs to an older item than any beat taken this edge
            if (out_ch.valid && out_ch.ready) begin
                if (lookup_q.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected result beat: result_q8 %h out_of_range %b",
                             $time, out_ch.result_q8, out_ch.out_of_range);
                end else begin
                    want = lookup_q.pop_front();
                    if (want.result_q8 !== out_ch.result_q8) begin
                        fails++;
                        $display("%0t: result_q8 mismatch: expected %h actual %h",
                                 $time, want.result_q8, out_ch.result_q8);
                    end
                    if (want.out_of_range !== out_ch.out_of_range) begin
                        fails++;
                        $display("%0t: out_of_range mismatch: expected %b actual %b",
                                 $time, want.out_of_range, out_ch.out_of_range);
                    end
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                case (in_ch.operation)
                    OP_WRITE:   entries[in_ch.entry_index] = in_ch.value;
                    OP_FORWARD: lookup_q.push_back(forward_result(longint'(in_ch.value)));
                    OP_REVERSE: lookup_q.push_back(reverse_result(longint'(in_ch.value)));
                    default: ;
                endcase
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_TREND_UP:   rising   = i_cfg_data[0];
                    CFG_STEP_SIZE:  step_reg = i_cfg_data;
                    CFG_BASE_VALUE: base_reg = i_cfg_data;
                    CFG_LAST_INDEX: last_reg = i_cfg_data[7:0];
                    default: ;
                endcase
            end
        end
        o_pending = lookup_q.size();
    end

endmodule

// ===== dv/tb_tracking_table_interpolator.sv =====
`timescale 1ns / 100ps
// Testbench top for the tracking table interpolator: clock, reset, table loads,
// directed and random lookups under several register settings, verdict.
// Depends on tti_pkg, tti_in_if, tti_out_if, tti_checker and the RTL.
module tb_tracking_table_interpolator;
    import tti_pkg::*;

    localparam int IDLE_LIMIT = 20000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fail_count;
    int                    pending;

    logic signed [31:0]    shadow[256];
    int                    cur_last, cur_step, cur_base;
    bit                    cur_rising;
    int                    burst_left = 0;
    int                    idle_cycles = 0;

    tti_in_if  in_ch();
    tti_out_if out_ch();

    tracking_table_interpolator dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    tti_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .in_ch        (in_ch),
        .out_ch       (out_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n           = 0;
        in_ch.valid       = 0;
        in_ch.operation   = OP_WRITE;
        in_ch.entry_index = '0;
        in_ch.value       = '0;
        out_ch.ready      = 0;
        cfg_we            = 0;
        cfg_idx           = CFG_TREND_UP;
        cfg_data          = '0;
    end

    // result side back-pressure
    initial begin
        int stall;
        int calm;
        calm = 0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (calm > 0) begin
                calm--;
                stall = 0;
            end else begin
                stall = $urandom_range(0, 14);
                if ($urandom_range(0, 9) == 0) calm = $urandom_range(5, 30);
            end
            if (stall > 0) begin
                out_ch.ready <= 0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1;
            do @(posedge i_clk); while (!out_ch.valid);
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic send_beat(logic [OP_W-1:0] op, logic [7:0] idx, logic signed [31:0] val);
        int gap;
        if (burst_left > 0) begin
            burst_left--;
            gap = 0;
        end else begin
            gap = $urandom_range(0, 14);
            if ($urandom_range(0, 19) == 0) burst_left = $urandom_range(10, 40);
        end
        if (gap > 0) begin
            in_ch.valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid       <= 1;
        in_ch.operation   <= op;
        in_ch.entry_index <= idx;
        in_ch.value       <= val;
        do @(posedge i_clk); while (!in_ch.ready);
        if (op == OP_WRITE) shadow[idx] = val;
    endtask

    task automatic drain();
        in_ch.valid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic set_config(bit rising, int stp, int base, int last);
        drain();
        cfg_we <= 1; cfg_idx <= CFG_TREND_UP;   cfg_data <= 16'(rising);
        @(posedge i_clk);
        cfg_idx <= CFG_STEP_SIZE;  cfg_data <= 16'(stp);
        @(posedge i_clk);
        cfg_idx <= CFG_BASE_VALUE; cfg_data <= 16'(base);
        @(posedge i_clk);
        cfg_idx <= CFG_LAST_INDEX; cfg_data <= 16'(last);
        @(posedge i_clk);
        cfg_we <= 0;
        cur_rising = rising;
        cur_step   = (stp == 0) ? 1 : stp;
        cur_base   = base;
        cur_last   = last;
    endtask

    // monotonic table in the current trend over the indices in use; flat runs included
    task automatic load_table(bit extremes);
        longint acc;
        longint val;
        acc = -(longint'(1) << 30) + $urandom_range(0, 1 << 20);
        for (int i = 0; i <= cur_last; i++) begin
            val = cur_rising ? acc : -acc;
            if (extremes && i == 0)        val = cur_rising ? -(longint'(1) << 31) : 32'h7fffffff;
            if (extremes && i == cur_last) val = cur_rising ? 32'h7fffffff : -(longint'(1) << 31);
            send_beat(OP_WRITE, 8'(i), 32'(val));
            acc += ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 1 << 22);
        end
    endtask

    task automatic random_lookups(int count);
        int     pick, k;
        longint val, diff;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                k   = $urandom_range(0, cur_last);
                val = shadow[k];
                if (k < cur_last && $urandom_range(0, 3) != 0) begin
                    diff = longint'(shadow[k + 1]) - longint'(shadow[k]);
                    val += diff * longint'($urandom_range(0, 255)) / 256;
                end
                send_beat(OP_FORWARD, 8'($urandom), 32'(val));
            end else if (pick < 85) begin
                if ($urandom_range(0, 9) == 0)
                    val = cur_base - $urandom_range(1, 1000);
                else
                    val = cur_base + $urandom_range(0, (cur_last + 1) * cur_step);
                send_beat(OP_REVERSE, 8'($urandom), 32'(val));
            end else if (pick < 92) begin
                send_beat(($urandom_range(0, 1) == 0) ? OP_FORWARD : OP_REVERSE,
                          8'($urandom), 32'($urandom));
            end else if (pick < 96) begin
                send_beat(OP_UNUSED, 8'($urandom), 32'($urandom));
            end else begin
                send_beat(OP_WRITE, 8'($urandom), 32'($urandom));
            end
        end
    endtask

    initial begin
        cur_rising = 1; cur_step = 1; cur_base = 0; cur_last = 255;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // defaults after reset, full-range table
        load_table(1);
        send_beat(OP_FORWARD, 8'd0,   32'sh7fffffff);
        send_beat(OP_FORWARD, 8'd0,   32'sh80000000);
        send_beat(OP_FORWARD, 8'd0,   shadow[10]);
        send_beat(OP_FORWARD, 8'd0,   shadow[20] + 1);
        send_beat(OP_FORWARD, 8'hff,  shadow[200] + 3);
        send_beat(OP_REVERSE, 8'd0,   -32'sd1);
        send_beat(OP_REVERSE, 8'd0,   32'sd255);
        send_beat(OP_REVERSE, 8'd0,   32'sd256);
        send_beat(OP_REVERSE, 8'd0,   32'sd3);
        send_beat(OP_UNUSED,  8'd5,   32'sd7);
        send_beat(OP_WRITE,   8'd255, 32'sh7ffffff0);
        send_beat(OP_FORWARD, 8'd0,   32'sh7fffffff);
        send_beat(OP_REVERSE, 8'd0,   32'sd255);
        random_lookups(60);

        set_config(1, 65535, -32768, 255);
        random_lookups(60);
        set_config(0, 300, 32767, 100);
        load_table(0);
        random_lookups(80);
        set_config(0, 0, -5, 1);
        random_lookups(50);
        set_config(1, 7, 1000, 0);
        load_table(0);
        random_lookups(40);
        set_config(1, 16, -100, 200);
        random_lookups(80);
        set_config(0, 65535, 0, 63);
        load_table(1);
        random_lookups(80);
        set_config(1, 1, 0, 40);
        load_table(0);
        random_lookups(60);

        drain();
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
